// ===== hw/rtl/rws_pkg.sv =====
// ----------------------------------------------------------------------------
// rws_pkg: shared constants and types for the radial wave sum block
// Table size, sine resolution, polynomial coefficients and the source entry.
// ----------------------------------------------------------------------------
package rws_pkg;

    // Table depth and derived index and count widths.
    localparam int MAX_SOURCES     = 16;
    localparam int IDX_W           = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CNT_W           = $clog2(MAX_SOURCES + 1);

    // Sine angle resolution in bits of a turn.
    localparam int SINE_TABLE_BITS = 10;
    localparam logic [15:0] ANGLE_MASK =
        16'(~((32'd1 << (16 - SINE_TABLE_BITS)) - 32'd1));

    // Odd polynomial coefficients of the quarter-wave sine, Q30.
    localparam logic [31:0] SC1 = 32'd1686629713;
    localparam logic [31:0] SC3 = 32'd693598668;
    localparam logic [31:0] SC5 = 32'd85569304;
    localparam logic [31:0] SC7 = 32'd5026993;
    localparam logic [31:0] SC9 = 32'd172274;

    // Command codes carried in the input tuser.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // One stored wave source.
    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] amplitude;
        logic        [30:0] wavelength;
    } t_source;

endpackage

// ===== hw/rtl/radial_wave_sum.sv =====
// ----------------------------------------------------------------------------
// radial_wave_sum: sum of radial sine waves from a table of sources
// Stores wave sources and, per query, accumulates amplitude-scaled sines of
// the distance phase of every active source, saturated to Q16.16.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word contents
//  s_axis    in         tuser: command; tdata: entry_index, center_x,
//                       center_y, amplitude, wavelength, query_x, query_y,
//                       angle_turns
//  m_axis    out        tuser: saturated; tdata: wave_sum
//  cfg       in         source_count
//
//  A write word is stored when accepted. A query walks the sources up to
//  the count: each active source runs the square root, the phase division
//  and the sine in turn, and a source with zero wavelength is skipped; the
//  serial root and divider set the query time.
//  Reset is synchronous and active low and clears control state only.
//  The input is not ready while a query runs. A finished query waits until
//  the previous result has left the output register.
// ----------------------------------------------------------------------------
module radial_wave_sum import rws_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bits from low: entry_index[3:0], center_x[35:4], center_y[67:36],
    // amplitude[99:68], wavelength[130:100], query_x[162:131],
    // query_y[194:163], angle_turns[210:195], zero pad[215:211]
    input  logic [215:0] s_axis_tdata,
    // bits from low: command[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bits from low: wave_sum[31:0]
    output logic [31:0]  m_axis_tdata,
    // bits from low: saturated[0]
    output logic         m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [4:0]   i_cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_NEXT, ST_ENTRY, ST_SQX, ST_SQY, ST_SQRT, ST_DIV,
        ST_SINE, ST_MAC, ST_ACC, ST_DONE
    } t_state;

    // Input word fields.
    logic [3:0]         w_entry;
    logic signed [31:0] w_qx;
    logic signed [31:0] w_qy;
    logic [15:0]        w_ang;
    t_source            w_src;

    assign w_entry          = s_axis_tdata[3:0];
    assign w_src.center_x   = s_axis_tdata[35:4];
    assign w_src.center_y   = s_axis_tdata[67:36];
    assign w_src.amplitude  = s_axis_tdata[99:68];
    assign w_src.wavelength = s_axis_tdata[130:100];
    assign w_qx             = s_axis_tdata[162:131];
    assign w_qy             = s_axis_tdata[194:163];
    assign w_ang            = s_axis_tdata[210:195];

    t_state             r_state;
    logic [4:0]         r_count_cfg;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_idx;
    logic signed [31:0] r_qx;
    logic signed [31:0] r_qy;
    logic [15:0]        r_ang;
    t_source            r_rd;
    logic [32:0]        r_ax;
    logic [32:0]        r_ay;
    logic [65:0]        r_sqx;
    logic [65:0]        r_sqy;
    logic [32:0]        r_dist;
    logic [15:0]        r_phase;
    logic signed [17:0] r_sine;
    logic signed [49:0] r_prod;
    logic signed [39:0] r_acc;
    logic               r_out_valid;
    logic [31:0]        r_out_sum;
    logic               r_out_sat;
    logic               r_sqrt_start;
    logic               r_div_start;
    logic               r_sine_start;

    t_source            r_mem [MAX_SOURCES];

    logic               n_in_acc;
    logic signed [32:0] n_dx;
    logic signed [32:0] n_dy;
    logic [32:0]        n_root;
    logic               n_root_done;
    logic [15:0]        n_phase;
    logic               n_phase_done;
    logic signed [17:0] n_sine;
    logic               n_sine_done;
    logic [CNT_W-1:0]   n_lim;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign n_in_acc      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Effective source count, limited to the table depth.
    assign n_lim = (32'(r_count_cfg) > 32'(MAX_SOURCES)) ? CNT_W'(MAX_SOURCES)
                                                          : CNT_W'(r_count_cfg);

    // Signed differences from the query point to the source center.
    assign n_dx = 33'(r_rd.center_x) - 33'(r_qx);
    assign n_dy = 33'(r_rd.center_y) - 33'(r_qy);

    // Source table: one write port for write words, one registered read.
    always_ff @(posedge i_clk) begin
        if (n_in_acc && s_axis_tuser == CMD_WRITE &&
            32'(w_entry) < 32'(MAX_SOURCES)) begin
            r_mem[IDX_W'(w_entry)] <= w_src;
        end
        r_rd <= r_mem[r_idx[IDX_W-1:0]];
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_cfg <= '0;
        end else if (i_cfg_valid) begin
            r_count_cfg <= i_cfg_data;
        end
    end

    rws_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sqrt_start),
        .i_radicand (r_sqx + r_sqy),
        .o_done     (n_root_done),
        .o_root     (n_root)
    );

    rws_phase_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_div_start),
        .i_distance   (r_dist),
        .i_wavelength (r_rd.wavelength),
        .o_done       (n_phase_done),
        .o_phase      (n_phase)
    );

    rws_sine u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sine_start),
        .i_angle (r_phase + r_ang),
        .o_done  (n_sine_done),
        .o_sine  (n_sine)
    );

    // Query sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_sqrt_start <= 1'b0;
            r_div_start  <= 1'b0;
            r_sine_start <= 1'b0;
            r_idx        <= '0;
        end else begin
            r_sqrt_start <= 1'b0;
            r_div_start  <= 1'b0;
            r_sine_start <= 1'b0;
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (n_in_acc && s_axis_tuser == CMD_QUERY) begin
                        r_qx    <= w_qx;
                        r_qy    <= w_qy;
                        r_ang   <= w_ang;
                        r_n     <= n_lim;
                        r_idx   <= '0;
                        r_acc   <= '0;
                        r_state <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    r_state <= (r_idx == r_n) ? ST_DONE : ST_ENTRY;
                end
                ST_ENTRY: begin
                    if (r_rd.wavelength == '0) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_NEXT;
                    end else begin
                        r_ax    <= n_dx[32] ? 33'(-n_dx) : 33'(n_dx);
                        r_ay    <= n_dy[32] ? 33'(-n_dy) : 33'(n_dy);
                        r_state <= ST_SQX;
                    end
                end
                ST_SQX: begin
                    r_sqx   <= r_ax * r_ax;
                    r_state <= ST_SQY;
                end
                ST_SQY: begin
                    r_sqy        <= r_ay * r_ay;
                    r_sqrt_start <= 1'b1;
                    r_state      <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (n_root_done) begin
                        r_dist      <= n_root;
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (n_phase_done) begin
                        r_phase      <= n_phase;
                        r_sine_start <= 1'b1;
                        r_state      <= ST_SINE;
                    end
                end
                ST_SINE: begin
                    if (n_sine_done) begin
                        r_sine  <= n_sine;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    r_prod  <= r_rd.amplitude * r_sine;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_acc   <= r_acc + 40'(r_prod >>> 16);
                    r_idx   <= r_idx + 1'b1;
                    r_state <= ST_NEXT;
                end
                ST_DONE: begin
                    // Load the result only once the output register is free.
                    if (!r_out_valid) begin
                        if (r_acc > 40'sd2147483647) begin
                            r_out_sum <= 32'h7FFF_FFFF;
                            r_out_sat <= 1'b1;
                        end else if (r_acc < -40'sd2147483648) begin
                            r_out_sum <= 32'h8000_0000;
                            r_out_sat <= 1'b1;
                        end else begin
                            r_out_sum <= r_acc[31:0];
                            r_out_sat <= 1'b0;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sum;
    assign m_axis_tuser  = r_out_sat;

endmodule

// ===== hw/rtl/rws_isqrt.sv =====
// ----------------------------------------------------------------------------
// rws_isqrt: iterative floor square root
// Restoring digit recurrence on a 66-bit radicand, two bits per cycle.
// ----------------------------------------------------------------------------
module rws_isqrt import rws_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [65:0] i_radicand,
    output logic        o_done,
    output logic [32:0] o_root
);

    logic        r_busy;
    logic [5:0]  r_count;
    logic [65:0] r_rad;
    logic [35:0] r_rem;
    logic [32:0] r_root;
    logic        r_done;

    logic [35:0] n_rem_sh;
    logic [35:0] n_trial;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
        n_rem_sh = {r_rem[33:0], r_rad[65:64]};
        n_trial  = {1'b0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= 6'd0;
                r_rad   <= i_radicand;
                r_rem   <= '0;
                r_root  <= '0;
            end else if (r_busy) begin
                r_rad <= {r_rad[63:0], 2'b00};
                if (n_rem_sh >= n_trial) begin
                    r_rem  <= n_rem_sh - n_trial;
                    r_root <= {r_root[31:0], 1'b1};
                end else begin
                    r_rem  <= n_rem_sh;
                    r_root <= {r_root[31:0], 1'b0};
                end
                r_count <= r_count + 6'd1;
                if (r_count == 6'd32) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hw/rtl/rws_phase_div.sv =====
// ----------------------------------------------------------------------------
// rws_phase_div: iterative wavelength phase divider
// Long division of the distance by the wavelength, continued for sixteen
// fraction bits so the last quotient bits are the phase in turns.
// ----------------------------------------------------------------------------
module rws_phase_div import rws_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_distance,
    input  logic [30:0] i_wavelength,
    output logic        o_done,
    output logic [15:0] o_phase
);

    logic        r_busy;
    logic [5:0]  r_count;
    logic [48:0] r_num;
    logic [30:0] r_den;
    logic [31:0] r_rem;
    logic [15:0] r_quo;
    logic        r_done;

    logic [31:0] n_rem_sh;
    logic        n_fit;

    // Shift in the next numerator bit and compare with the divisor.
    always_comb begin
        n_rem_sh = {r_rem[30:0], r_num[48]};
        n_fit    = n_rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= 6'd0;
                r_num   <= {i_distance, 16'd0};
                r_den   <= i_wavelength;
                r_rem   <= '0;
                r_quo   <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[47:0], 1'b0};
                r_rem <= n_fit ? (n_rem_sh - {1'b0, r_den}) : n_rem_sh;
                r_quo <= {r_quo[14:0], n_fit};
                r_count <= r_count + 6'd1;
                if (r_count == 6'd48) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_phase = r_quo;

endmodule

// ===== hw/rtl/rws_sine.sv =====
// ----------------------------------------------------------------------------
// rws_sine: sequential quarter-wave sine
// Evaluates the odd polynomial by Horner steps on one shared multiplier.
// ----------------------------------------------------------------------------
module rws_sine import rws_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_angle,
    output logic               o_done,
    output logic signed [17:0] o_sine
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_Z2, ST_Z2, ST_MUL, ST_ACC, ST_MUL_FIN, ST_OUT
    } t_state;

    t_state             r_state;
    logic [1:0]         r_quad;
    logic [30:0]        r_z;
    logic [30:0]        r_z2;
    logic [31:0]        r_acc;
    logic [62:0]        r_p;
    logic [1:0]         r_k;
    logic               r_done;
    logic signed [17:0] r_sine;

    logic [15:0] n_ang;
    logic [13:0] n_r;
    logic [14:0] n_rf;
    logic [31:0] n_ma;
    logic [30:0] n_mb;
    logic [31:0] n_coef;
    logic [32:0] n_round;
    logic [18:0] n_s;
    logic [16:0] n_sc;

    // Quantize the angle and fold it into the first quadrant.
    always_comb begin
        n_ang = i_angle & ANGLE_MASK;
        n_r   = n_ang[13:0];
        n_rf  = n_ang[14] ? (15'd16384 - {1'b0, n_r}) : {1'b0, n_r};
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_state)
            ST_MUL_Z2: begin
                n_ma = {1'b0, r_z};
                n_mb = r_z;
            end
            ST_MUL: begin
                n_ma = r_acc;
                n_mb = r_z2;
            end
            default: begin
                n_ma = r_acc;
                n_mb = r_z;
            end
        endcase
    end

    // Coefficient for the current Horner step.
    always_comb begin
        unique case (r_k)
            2'd0:    n_coef = SC7;
            2'd1:    n_coef = SC5;
            2'd2:    n_coef = SC3;
            default: n_coef = SC1;
        endcase
    end

    // Round the final product to Q1.16 and limit it to one.
    always_comb begin
        n_round = r_p[62:30] + 33'd8192;
        n_s     = n_round[32:14];
        n_sc    = (n_s > 19'd65536) ? 17'd65536 : n_s[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_quad  <= n_ang[15:14];
                        r_z     <= {n_rf, 16'd0};
                        r_state <= ST_MUL_Z2;
                    end
                end
                ST_MUL_Z2: begin
                    r_p     <= n_ma * n_mb;
                    r_state <= ST_Z2;
                end
                ST_Z2: begin
                    r_z2    <= r_p[60:30];
                    r_acc   <= SC9;
                    r_k     <= 2'd0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_p     <= n_ma * n_mb;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_acc <= 32'(n_coef - r_p[62:31+1-2]);
                    r_k   <= r_k + 2'd1;
                    r_state <= (r_k == 2'd3) ? ST_MUL_FIN : ST_MUL;
                end
                ST_MUL_FIN: begin
                    r_p     <= n_ma * n_mb;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    r_sine  <= r_quad[1] ? -$signed({1'b0, n_sc}) : $signed({1'b0, n_sc});
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sine = r_sine;

endmodule

// ===== dv/tb_radial_wave_sum.sv =====
// ----------------------------------------------------------------------------
// tb_radial_wave_sum: self-checking testbench for the radial wave sum block
// Writes source tables, runs queries through a stream driver with random
// gaps, predicts each sum with an independent fixed-point model and checks
// every result word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_radial_wave_sum;
    import rws_pkg::*;

    // Input word as the driver sends it.
    typedef struct {
        logic        cmd;
        logic [3:0]  idx;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] amp;
        logic [30:0] wl;
        logic [31:0] qx;
        logic [31:0] qy;
        logic [15:0] ang;
    } t_word;

    typedef struct {
        logic [31:0] sum;
        logic        sat;
    } t_sum;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [215:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [4:0]   i_cfg_data;

    radial_wave_sum u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // Predictor state.
    logic signed [31:0] tab_cx [MAX_SOURCES];
    logic signed [31:0] tab_cy [MAX_SOURCES];
    logic signed [31:0] tab_amp [MAX_SOURCES];
    logic [30:0]        tab_wl [MAX_SOURCES];
    logic [4:0]         count_reg;

    t_word  pending_words[$];
    t_sum   expected_sums[$];
    int     error_count;
    int     idle_cycles;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off;

    // Acceptance seen at the rising edge.
    logic s_axis_tready_q;

    // Clock.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Quantized quarter-wave polynomial sine, Q16.16.
    function automatic logic signed [31:0] wave_sine(input logic [15:0] a);
        logic [15:0] p;
        logic [1:0]  quad;
        logic [63:0] r, z, z2, acc, s;
        p = a & ANGLE_MASK;
        quad = p[15:14];
        r = {50'd0, p[13:0]};
        if (quad[0]) r = 64'd16384 - r;
        z = r << 16;
        z2 = (z * z) >> 30;
        acc = SC9;
        acc = SC7 - ((acc * z2) >> 30);
        acc = SC5 - ((acc * z2) >> 30);
        acc = SC3 - ((acc * z2) >> 30);
        acc = SC1 - ((acc * z2) >> 30);
        s = (((z * acc) >> 30) + 64'd8192) >> 14;
        if (s > 64'd65536) s = 64'd65536;
        return quad[1] ? -32'(s) : 32'(s);
    endfunction

    // Sum of all active sources at one point.
    function automatic t_sum wave_sum_at(input logic signed [31:0] qx,
                                         input logic signed [31:0] qy,
                                         input logic [15:0] ang);
        t_sum res;
        logic signed [65:0] acc;
        logic signed [33:0] dx, dy;
        logic [65:0] sq, t;
        logic [32:0] d;
        logic [63:0] ph;
        logic signed [65:0] prod;
        int n;
        acc = 0;
        n = (count_reg > MAX_SOURCES) ? MAX_SOURCES : count_reg;
        for (int i = 0; i < n; i++) begin
            if (tab_wl[i] != 0) begin
                dx = 34'(tab_cx[i]) - 34'(qx);
                dy = 34'(tab_cy[i]) - 34'(qy);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                sq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
                d = 0;
                for (int b = 32; b >= 0; b--) begin
                    t = 66'(d | (33'd1 << b));
                    if (t * t <= sq) d = 33'(t);
                end
                ph = ((64'(d) % 64'(tab_wl[i])) << 16) / 64'(tab_wl[i]);
                prod = 66'(tab_amp[i]) * 66'(wave_sine(16'(ph) + ang));
                acc = acc + (prod >>> 16);
            end
        end
        res.sat = 1'b1;
        if (acc > 66'sd2147483647) res.sum = 32'h7FFFFFFF;
        else if (acc < -66'sd2147483648) res.sum = 32'h80000000;
        else begin
            res.sum = acc[31:0];
            res.sat = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'($signed($urandom_range(0, 200)) - 100) << 16;
        endcase
    endfunction

    function automatic t_word make_write(input logic [3:0] idx);
        t_word w;
        w.cmd = CMD_WRITE;
        w.idx = idx;
        w.cx = rand_coord();
        w.cy = rand_coord();
        w.amp = ($urandom_range(0, 3) == 0) ? $urandom() : rand_coord();
        case ($urandom_range(0, 4))
            0: w.wl = 31'($urandom());
            1: w.wl = 31'($urandom_range(1, 100));
            2: w.wl = 0;
            default: w.wl = 31'($urandom_range(1, 300)) << 16;
        endcase
        w.qx = $urandom();
        w.qy = $urandom();
        w.ang = 16'($urandom());
        return w;
    endfunction

    function automatic t_word make_query();
        t_word w;
        w = make_write(4'($urandom()));
        w.cmd = CMD_QUERY;
        w.qx = rand_coord();
        w.qy = rand_coord();
        return w;
    endfunction

    // Driver: offers pending words and holds a word until it is accepted.
    always @(negedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready_q) begin
            void'(pending_words.pop_front());
        end
        if (pending_words.size() > 0 && ($urandom_range(0, 99) >= send_idle_pct
                || s_axis_tvalid && !s_axis_tready_q)) begin
            t_word w;
            w = pending_words[0];
            s_axis_tvalid <= 1'b1;
            s_axis_tuser <= w.cmd;
            s_axis_tdata <= {5'd0, w.ang, w.qy, w.qx, w.wl, w.amp, w.cy, w.cx, w.idx};
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random ready, or a counted stretch of holding off.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            m_axis_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Monitor: updates the prediction on acceptance and checks results.
    always @(posedge i_clk) begin
        s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                t_word w;
                w = pending_words[0];
                if (w.cmd == CMD_WRITE) begin
                    tab_cx[w.idx] = w.cx;
                    tab_cy[w.idx] = w.cy;
                    tab_amp[w.idx] = w.amp;
                    tab_wl[w.idx] = w.wl;
                end else begin
                    expected_sums.push_back(wave_sum_at(w.qx, w.qy, w.ang));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_sums.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, 32'd0);
                end else begin
                    t_sum e;
                    e = expected_sums.pop_front();
                    if (m_axis_tdata !== e.sum)
                        report_mismatch("wave_sum", m_axis_tdata, e.sum);
                    if (m_axis_tuser !== e.sat)
                        report_mismatch("saturated", 32'(m_axis_tuser), 32'(e.sat));
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog on cycles without progress.
    always @(posedge i_clk) begin
        if (idle_cycles > 60000) begin
            $display("radial_wave_sum verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() > 0 || expected_sums.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [4:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        count_reg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic fill_table();
        for (int i = 0; i < MAX_SOURCES; i++)
            pending_words.push_back(make_write(4'(i)));
    endtask

    initial begin
        t_word w;
        int cnt;
        error_count = 0;
        hold_off = 0;
        count_reg = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        s_axis_tready_q = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes of the table and the query point.
        fill_table();
        w = make_write(4'd0);
        w.cx = 32'h80000000; w.cy = 32'h80000000; w.amp = 32'h7FFFFFFF;
        w.wl = 31'h7FFFFFFF;
        pending_words.push_back(w);
        w = make_write(4'd1);
        w.cx = 32'h7FFFFFFF; w.cy = 32'h7FFFFFFF; w.amp = 32'h80000000; w.wl = 31'd1;
        pending_words.push_back(w);
        w = make_write(4'd2);
        w.wl = 0;
        pending_words.push_back(w);
        wait_drained();
        write_count(5'd0);
        w = make_query();
        pending_words.push_back(w);
        wait_drained();
        write_count(5'd31);
        for (int k = 0; k < 6; k++) begin
            w = make_query();
            if (k == 0) begin w.qx = 32'h7FFFFFFF; w.qy = 32'h7FFFFFFF; w.ang = 16'hFFFF; end
            if (k == 1) begin w.qx = 32'h80000000; w.qy = 32'h80000000; w.ang = 16'h0000; end
            pending_words.push_back(w);
        end
        // Large amplitudes at one point to force saturation both ways.
        for (int i = 0; i < MAX_SOURCES; i++) begin
            w = make_write(4'(i));
            w.cx = 0; w.cy = 0; w.wl = 31'h10000;
            w.amp = 32'h7FFFFFFF;
            pending_words.push_back(w);
        end
        w = make_query(); w.qx = 0; w.qy = 0; w.ang = 16'h4000;
        pending_words.push_back(w);
        w = make_query(); w.qx = 0; w.qy = 0; w.ang = 16'hC000;
        pending_words.push_back(w);
        wait_drained();
        write_count(5'd16);

        // Random phases with changing idling and count.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 70 : 0;
            recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 36 : 0;
            for (int b = 0; b < 4; b++) begin
                cnt = (b == 0) ? 16 : (b == 1) ? 1 : $urandom_range(2, 6);
                wait_drained();
                write_count(5'(cnt));
                fill_table();
                for (int k = 0; k < 29; k++) begin
                    if ($urandom_range(0, 3) == 0)
                        pending_words.push_back(make_write(4'($urandom())));
                    else
                        pending_words.push_back(make_query());
                end
                if (phase == 2 && b == 1) hold_off = 3000;
            end
        end
        wait_drained();
        if (error_count == 0) begin
            $display("radial_wave_sum verification clean");
        end else begin
            $display("radial_wave_sum verification failed");
        end
        $finish;
    end

endmodule
